// File: design/ric_pkg.sv
`timescale 1ns / 1ps
package ric_pkg;

   // Field widths fixed by the transaction format
   localparam int OP_W     = 1;
   localparam int DEV_W    = 16;
   localparam int INO_W    = 12;
   localparam int SLOT_W   = 6;
   localparam int STAT_W   = 3;
   localparam int COUNT_W  = 8;
   localparam int SECT_W   = 21;
   localparam int OFFS_W   = 9;
   localparam int IMAP_W   = 8;
   localparam int CSR_IDX_W = 1;

   // Boot sector plus super block ahead of the maps
   localparam logic [SECT_W+1:0] LEAD_SECTORS = (SECT_W+2)'(1 + 1);
   localparam logic [SECT_W-1:0] MAX_SECTOR   = {SECT_W{1'b1}};
   localparam logic [COUNT_W-1:0] MAX_COUNT   = {COUNT_W{1'b1}};

   // Request kinds
   localparam logic [OP_W-1:0] OP_ACQUIRE = 1'b0;
   localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

   // Response status codes
   localparam logic [STAT_W-1:0] STAT_HIT      = 3'd0;
   localparam logic [STAT_W-1:0] STAT_LOAD     = 3'd1;
   localparam logic [STAT_W-1:0] STAT_NULL     = 3'd2;
   localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] STAT_BAD_REL  = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAP = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMAP = 1'b1;

   // One slot of the table
   typedef struct packed {
      logic [COUNT_W-1:0] refs;
      logic [DEV_W-1:0]   dev;
      logic [INO_W-1:0]   ino;
   } entry_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RELRD,
      S_SCAN,
      S_DIV,
      S_ADDR,
      S_DONE
   } state_type;

endpackage

// File: design/refcounted_inode_cache.sv
`timescale 1ns / 1ps
// Reference-counted inode slot table.
// Request channel (req_): tuser is the operation (0 acquire, 1 release); tdata carries
// device, inode number and the slot to release. Response channel (rsp_): tuser is the
// status, tdata the slot, its count after the transaction and, for a new slot, the disk
// sector and byte offset to load the inode from. Exactly one response per request.
// Configuration channel (csr_): index 0 inode-map sectors, 1 sector-map sectors; always
// ready; write it only while the block is idle: the block itself does not enforce this.
// All slots sit in one memory with a registered read port; one request is worked at a time.
// Release: read, update and output register from acceptance to response valid.
// Acquire: the scan reads one slot a cycle and stops at a hit; a miss or full table scans
// every slot. A new slot then passes S_DIV, the reciprocal multiply that gives the
// quotient of the inode number by INODES_PER_SECTOR, and S_ADDR for the remainder,
// offset and sector sum.
// A null inode or an out-of-range release goes straight to the done state.
// After reset a clearing pass writes every slot free, with req_tready low.
// The response sits in an output register; while the receiver stalls, the next request is
// still accepted and worked, and it waits in the done state until the register frees.
module refcounted_inode_cache
   import ric_pkg::*;
#(
   parameter int SLOTS             = 64,
   parameter int INODES_PER_SECTOR = 16,
   parameter int SECTOR_BYTES      = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [OP_W-1:0]      req_tuser,   // operation
   input  logic [39:0]          req_tdata,   // device[15:0], inode_number[27:16], slot[33:28]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [STAT_W-1:0]    rsp_tuser,   // status
   output logic [47:0]          rsp_tdata,   // slot_index[5:0], ref_count[13:6],
                                             // load_sector[34:14], load_offset[43:35]
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SECT_W-1:0]    csr_data
);

   localparam int AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int RW  = (AW > SLOT_W) ? AW : SLOT_W;
   localparam int DW  = $clog2(INODES_PER_SECTOR + 1);
   localparam int BYTES_PER_INODE = SECTOR_BYTES / INODES_PER_SECTOR;
   localparam int PW  = DW + 13;
   localparam int RECIP_SH = 24;
   localparam int RECIP_W  = RECIP_SH + 1;
   localparam int QP_W     = INO_W + RECIP_W;
   localparam logic [AW-1:0]      LAST_SLOT = AW'(SLOTS - 1);
   localparam logic [INO_W-1:0]   DIVISOR   = INO_W'(INODES_PER_SECTOR);
   // Rounded-up reciprocal, exact for every 12-bit inode number
   localparam logic [RECIP_W-1:0] RECIP     =
      RECIP_W'((2**RECIP_SH + INODES_PER_SECTOR - 1) / INODES_PER_SECTOR);

   // Slot memory
   entry_type mem [SLOTS];
   entry_type rd_data_ff;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   entry_type         mem_wr_data;
   logic [AW-1:0]     mem_rd_addr;

   // Control registers
   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [AW-1:0]     chk_ff, chk_in;
   logic [AW-1:0]     free_ff, free_in;
   logic              have_free_ff, have_free_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IMAP_W-1:0] imap_ff, imap_in;
   logic [SECT_W-1:0] smap_ff, smap_in;

   // Payload registers
   logic [DEV_W-1:0]   dev_ff;
   logic [INO_W-1:0]   ino_ff;
   logic [SLOT_W-1:0]  rel_ff;
   logic [INO_W-1:0]   quo_ff, quo_in;
   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic [SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;
   logic [SECT_W-1:0]  res_sector_ff, res_sector_in;
   logic [OFFS_W-1:0]  res_offset_ff, res_offset_in;
   logic [STAT_W-1:0]  out_status_ff;
   logic [47:0]        out_data_ff;

   // Request fields
   logic               req_accept;
   logic [DEV_W-1:0]   req_dev;
   logic [INO_W-1:0]   req_ino;
   logic [SLOT_W-1:0]  req_rel;
   logic [RW-1:0]      req_rel_ext;
   logic [RW-1:0]      rel_ff_ext;
   logic               req_rel_ok;

   // Scan and arithmetic helpers
   logic               key_hit;
   logic               is_free;
   logic [AW-1:0]      claim_idx;
   logic [RW-1:0]      chk_ext;
   logic [RW-1:0]      claim_ext;
   logic [COUNT_W-1:0] inc_count;
   logic [INO_W-1:0]   ino_less;
   logic [QP_W-1:0]    quo_prod;
   logic [INO_W-1:0]   quo_back;
   logic [INO_W-1:0]   div_rem_full;
   logic [DW-1:0]      div_rem;
   logic [SECT_W+1:0]  sector_sum;
   logic [PW-1:0]      off_prod;

   assign req_accept = req_tvalid && req_tready;
   assign req_dev    = req_tdata[15:0];
   assign req_ino    = req_tdata[27:16];
   assign req_rel    = req_tdata[33:28];
   assign req_rel_ext = RW'(req_rel);
   assign rel_ff_ext  = RW'(rel_ff);
   assign req_rel_ok  = 32'(req_rel) < 32'(SLOTS);

   assign key_hit   = (rd_data_ff.refs != '0) && (rd_data_ff.dev == dev_ff)
                      && (rd_data_ff.ino == ino_ff);
   assign is_free   = (rd_data_ff.refs == '0);
   assign claim_idx = have_free_ff ? free_ff : chk_ff;
   assign chk_ext   = RW'(chk_ff);
   assign claim_ext = RW'(claim_idx);
   assign inc_count = (rd_data_ff.refs == MAX_COUNT) ? MAX_COUNT
                      : COUNT_W'(rd_data_ff.refs + 1'b1);

   // Quotient by reciprocal multiplication, remainder by multiply back and subtract
   assign ino_less     = INO_W'(ino_ff - 1'b1);
   assign quo_prod     = QP_W'(ino_less) * QP_W'(RECIP);
   assign quo_back     = INO_W'(quo_ff * DIVISOR);
   assign div_rem_full = INO_W'(ino_less - quo_back);
   assign div_rem      = div_rem_full[DW-1:0];

   assign sector_sum = LEAD_SECTORS + (SECT_W+2)'(imap_ff) + (SECT_W+2)'(smap_ff)
                       + (SECT_W+2)'(quo_ff);
   assign off_prod   = PW'(div_rem) * PW'(BYTES_PER_INODE);

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = out_data_ff;

   // Next state, memory access and result
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      chk_in        = chk_ff;
      free_in       = free_ff;
      have_free_in  = have_free_ff;
      quo_in        = quo_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_count_in  = res_count_ff;
      res_sector_in = res_sector_ff;
      res_offset_in = res_offset_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = chk_ff;
      mem_wr_data   = rd_data_ff;
      mem_rd_addr   = '0;

      unique case (state_ff)
         S_CLEAR: begin
            // Free one slot a cycle
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = AW'(clr_ff + 1'b1);
            if (clr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tuser == OP_RELEASE) begin
               mem_rd_addr = req_rel_ext[AW-1:0];
            end
            if (req_accept) begin
               res_sector_in = '0;
               res_offset_in = '0;
               res_count_in  = '0;
               if (req_tuser == OP_RELEASE) begin
                  res_slot_in = req_rel;
                  if (req_rel_ok) begin
                     state_in = S_RELRD;
                  end else begin
                     res_status_in = STAT_BAD_REL;
                     state_in      = S_DONE;
                  end
               end else if (req_ino == '0) begin
                  res_status_in = STAT_NULL;
                  res_slot_in   = '0;
                  state_in      = S_DONE;
               end else begin
                  chk_in       = '0;
                  have_free_in = 1'b0;
                  state_in     = S_SCAN;
               end
            end
         end
         S_RELRD: begin
            if (is_free) begin
               res_status_in = STAT_BAD_REL;
            end else begin
               mem_wr_en        = 1'b1;
               mem_wr_addr      = rel_ff_ext[AW-1:0];
               mem_wr_data.refs = COUNT_W'(rd_data_ff.refs - 1'b1);
               res_status_in    = STAT_HIT;
               res_count_in     = COUNT_W'(rd_data_ff.refs - 1'b1);
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            mem_rd_addr = AW'(chk_ff + 1'b1);
            if (key_hit) begin
               mem_wr_en        = 1'b1;
               mem_wr_addr      = chk_ff;
               mem_wr_data.refs = inc_count;
               res_status_in    = STAT_HIT;
               res_slot_in      = chk_ext[SLOT_W-1:0];
               res_count_in     = inc_count;
               state_in         = S_DONE;
            end else begin
               if (is_free && !have_free_ff) begin
                  have_free_in = 1'b1;
                  free_in      = chk_ff;
               end
               if (chk_ff == LAST_SLOT) begin
                  if (have_free_ff || is_free) begin
                     // Claim the lowest free slot and start the sector arithmetic
                     mem_wr_en     = 1'b1;
                     mem_wr_addr   = claim_idx;
                     mem_wr_data   = '{refs: COUNT_W'(1), dev: dev_ff, ino: ino_ff};
                     res_status_in = STAT_LOAD;
                     res_slot_in   = claim_ext[SLOT_W-1:0];
                     res_count_in  = COUNT_W'(1);
                     state_in      = S_DIV;
                  end else begin
                     res_status_in = STAT_FULL;
                     res_slot_in   = '0;
                     state_in      = S_DONE;
                  end
               end else begin
                  chk_in = AW'(chk_ff + 1'b1);
               end
            end
         end
         S_DIV: begin
            // Hold the sector index within the inode table
            quo_in   = quo_prod[RECIP_SH +: INO_W];
            state_in = S_ADDR;
         end
         S_ADDR: begin
            // Saturate the sector, keep the offset to its field
            res_sector_in = (sector_sum > (SECT_W+2)'(MAX_SECTOR)) ? MAX_SECTOR
                            : sector_sum[SECT_W-1:0];
            res_offset_in = off_prod[OFFS_W-1:0];
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Configuration writes
   always_comb begin
      imap_in = imap_ff;
      smap_in = smap_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAP: imap_in = csr_data[IMAP_W-1:0];
            CSR_SMAP: smap_in = csr_data;
            default:  imap_in = imap_ff;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         chk_ff       <= '0;
         free_ff      <= '0;
         have_free_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         imap_ff      <= IMAP_W'(1);
         smap_ff      <= SECT_W'(1);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_ff       <= chk_in;
         free_ff      <= free_in;
         have_free_ff <= have_free_in;
         rsp_valid_ff <= rsp_valid_in;
         imap_ff      <= imap_in;
         smap_ff      <= smap_in;
      end
   end

   // Capture the request and hold the working result
   always_ff @(posedge clock) begin
      if (req_accept) begin
         dev_ff <= req_dev;
         ino_ff <= req_ino;
         rel_ff <= req_rel;
      end
      quo_ff        <= quo_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_count_ff  <= res_count_in;
      res_sector_ff <= res_sector_in;
      res_offset_ff <= res_offset_in;
   end

   // Load the output register when the result is handed over
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
         out_status_ff <= res_status_ff;
         out_data_ff   <= {4'b0, res_offset_ff, res_sector_ff, res_count_ff, res_slot_ff};
      end
   end

   // Slot memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= mem[mem_rd_addr];
   end

   // A request is taken only once per transaction
   a_single_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted twice in a row");

   // A new slot always reports count one
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_LOAD |-> rsp_tdata[13:6] == COUNT_W'(1))
      else $error("new slot without count one");

   // Load location only accompanies a new slot
   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_LOAD |-> rsp_tdata[43:14] == '0)
      else $error("load location on a response without load");

   // The table is never written while idle
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !mem_wr_en)
      else $error("slot write while idle");

   // A finished result waits only while the output is occupied
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && !rsp_valid_ff |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("result not handed to a free output");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;
   import ric_pkg::*;

   localparam int SLOTS             = 64;
   localparam int INODES_PER_SECTOR = 16;
   localparam int SECTOR_BYTES      = 512;
   localparam int HOLD_CYCLES       = 300;
   localparam int SETTLE_CYCLES     = 100;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DEV_W-1:0]  dev;
      logic [INO_W-1:0]  ino;
      logic [SLOT_W-1:0] slot;
   } inode_req_t;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] count;
      logic [SECT_W-1:0]  sector;
      logic [OFFS_W-1:0]  offset;
   } inode_rsp_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [OP_W-1:0]      req_tuser = '0;
   logic [39:0]          req_tdata = '0;   // device[15:0], inode_number[27:16], slot[33:28]
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [STAT_W-1:0]    rsp_tuser;        // status
   logic [47:0]          rsp_tdata;        // slot_index[5:0], ref_count[13:6],
                                           // load_sector[34:14], load_offset[43:35]
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SECT_W-1:0]    csr_data = '0;

   // Predicted table contents and register copies
   logic [COUNT_W-1:0] slot_refs [SLOTS];
   logic [DEV_W-1:0]   slot_dev  [SLOTS];
   logic [INO_W-1:0]   slot_ino  [SLOTS];
   logic [IMAP_W-1:0]  cfg_imap = 8'd1;
   logic [SECT_W-1:0]  cfg_smap = 21'd1;

   inode_req_t pending_reqs [$];
   inode_rsp_t expected_rsps [$];
   inode_req_t on_bus;
   inode_rsp_t mon_want;
   inode_rsp_t mon_got;

   int req_queued   = 0;
   int rsp_checked  = 0;
   int errors       = 0;
   int input_stalls = 0;
   int status_seen [5] = '{0, 0, 0, 0, 0};
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_rsp = 1'b0;

   logic [DEV_W-1:0] key_dev [16];
   logic [INO_W-1:0] key_ino [16];

   refcounted_inode_cache #(
      .SLOTS             (SLOTS),
      .INODES_PER_SECTOR (INODES_PER_SECTOR),
      .SECTOR_BYTES      (SECTOR_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Apply one request to the predicted table and return the response it causes
   function automatic inode_rsp_t lookup_inode(inode_req_t rq);
      inode_rsp_t rs;
      int free_slot;
      int unsigned n1;
      int unsigned sector;
      rs = '0;
      free_slot = -1;
      if (rq.op == OP_RELEASE) begin
         rs.slot = rq.slot;
         if (slot_refs[rq.slot] == '0) begin
            rs.status = STAT_BAD_REL;
         end else begin
            slot_refs[rq.slot] = slot_refs[rq.slot] - 1'b1;
            rs.status = STAT_HIT;
            rs.count  = slot_refs[rq.slot];
         end
         return rs;
      end
      if (rq.ino == '0) begin
         rs.status = STAT_NULL;
         return rs;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_refs[i] != '0) begin
            if (slot_dev[i] == rq.dev && slot_ino[i] == rq.ino) begin
               // saturate the count on a hit
               if (slot_refs[i] != MAX_COUNT) slot_refs[i] = slot_refs[i] + 1'b1;
               rs.status = STAT_HIT;
               rs.slot   = SLOT_W'(i);
               rs.count  = slot_refs[i];
               return rs;
            end
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (free_slot < 0) begin
         rs.status = STAT_FULL;
         return rs;
      end
      slot_dev[free_slot]  = rq.dev;
      slot_ino[free_slot]  = rq.ino;
      slot_refs[free_slot] = 8'd1;
      n1 = 32'(rq.ino) - 32'd1;
      sector = 32'(LEAD_SECTORS) + 32'(cfg_imap) + 32'(cfg_smap) + n1 / INODES_PER_SECTOR;
      if (sector > 32'(MAX_SECTOR)) sector = 32'(MAX_SECTOR);
      rs.status = STAT_LOAD;
      rs.slot   = SLOT_W'(free_slot);
      rs.count  = 8'd1;
      rs.sector = SECT_W'(sector);
      rs.offset = OFFS_W'((n1 % INODES_PER_SECTOR) * (SECTOR_BYTES / INODES_PER_SECTOR));
      return rs;
   endfunction

   // Driver: predict each accepted transaction, then offer the next pending one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(lookup_inode(on_bus));
         end
         if (req_tvalid && !req_tready && hold_rsp) input_stalls++;
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= on_bus.op;
               req_tdata  <= {6'b0, on_bus.slot, on_bus.ino, on_bus.dev};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Monitor: compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            mon_got.status = rsp_tuser;
            mon_got.slot   = rsp_tdata[5:0];
            mon_got.count  = rsp_tdata[13:6];
            mon_got.sector = rsp_tdata[34:14];
            mon_got.offset = rsp_tdata[43:35];
            if (expected_rsps.size() == 0) begin
               $display("%0t ns: unexpected response, expected none actual status %0d slot %0d",
                        $time, mon_got.status, mon_got.slot);
               errors++;
            end else begin
               mon_want = expected_rsps.pop_front();
               check_field("status", 32'(mon_want.status), 32'(mon_got.status));
               check_field("slot_index", 32'(mon_want.slot), 32'(mon_got.slot));
               check_field("ref_count", 32'(mon_want.count), 32'(mon_got.count));
               check_field("load_sector", 32'(mon_want.sector), 32'(mon_got.sector));
               check_field("load_offset", 32'(mon_want.offset), 32'(mon_got.offset));
               if (mon_want.status <= STAT_BAD_REL) status_seen[mon_want.status]++;
               rsp_checked++;
            end
         end
         rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic add_req(logic [OP_W-1:0] op, logic [DEV_W-1:0] dev,
                          logic [INO_W-1:0] ino, logic [SLOT_W-1:0] slot);
      inode_req_t rq;
      rq.op   = op;
      rq.dev  = dev;
      rq.ino  = ino;
      rq.slot = slot;
      pending_reqs.push_back(rq);
      req_queued++;
   endtask

   task automatic wait_drain();
      wait (rsp_checked == req_queued);
      @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [SECT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_IMAP) cfg_imap = value[IMAP_W-1:0];
      else cfg_smap = value;
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      @(posedge clock);
      send_idle_pct <= send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   // Mixed traffic in chunks; some releases aim at slots in use when the chunk starts, others at random slots
   task automatic queue_mixed(int count);
      int in_use [$];
      int pick;
      int k;
      while (count > 0) begin
         wait (rsp_checked == req_queued);
         in_use.delete();
         for (int s = 0; s < SLOTS; s++) if (slot_refs[s] != '0) in_use.push_back(s);
         for (k = 0; k < 16 && count > 0; k++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
               add_req(OP_ACQUIRE, key_dev[pick % 16], key_ino[pick % 16],
                       SLOT_W'($urandom));
            end else if (pick < 75 && in_use.size() > 0) begin
               add_req(OP_RELEASE, DEV_W'($urandom), INO_W'($urandom),
                       SLOT_W'(in_use[$urandom_range(in_use.size() - 1)]));
            end else if (pick < 83) begin
               add_req(OP_RELEASE, DEV_W'($urandom), INO_W'($urandom), SLOT_W'($urandom));
            end else if (pick < 90) begin
               add_req(OP_ACQUIRE, DEV_W'($urandom), '0, SLOT_W'($urandom));
            end else begin
               add_req(OP_ACQUIRE, DEV_W'($urandom), INO_W'($urandom_range(1, 4095)),
                       SLOT_W'($urandom));
            end
            count--;
         end
      end
   endtask

   // Stimulus
   initial begin
      int release_list [$];
      int tmp;
      int j;
      logic [DEV_W-1:0] sat_dev;
      logic [INO_W-1:0] sat_ino;

      for (int s = 0; s < SLOTS; s++) begin
         slot_refs[s] = '0;
         slot_dev[s]  = '0;
         slot_ino[s]  = '0;
      end
      for (int i = 0; i < 16; i++) begin
         key_dev[i] = DEV_W'($urandom);
         key_ino[i] = INO_W'($urandom_range(1, 4095));
      end
      key_dev[0] = 16'hFFFF;
      key_ino[0] = 12'hFFF;
      key_dev[1] = 16'h0000;
      key_ino[1] = 12'd1;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // hold off until the clearing pass is done
      do @(posedge clock); while (!req_tready);

      // Directed part at reset register values
      set_idling(9, 82);
      add_req(OP_ACQUIRE, 16'h0000, 12'd0, 6'd0);     // null inode
      add_req(OP_ACQUIRE, 16'hFFFF, 12'd0, 6'h3F);    // null inode, all-ones key
      add_req(OP_ACQUIRE, 16'h0000, 12'd1, 6'd0);     // load into slot 0
      add_req(OP_ACQUIRE, 16'hFFFF, 12'hFFF, 6'd0);   // load, largest inode number
      add_req(OP_ACQUIRE, 16'h0000, 12'd1, 6'h3F);    // hit
      add_req(OP_ACQUIRE, 16'hFFFF, 12'hFFF, 6'd0);   // hit
      add_req(OP_RELEASE, 16'h0000, 12'd0, 6'd0);
      add_req(OP_RELEASE, 16'h0000, 12'd0, 6'd0);     // count drops to zero
      add_req(OP_RELEASE, 16'h0000, 12'd0, 6'd0);     // release of a free slot
      add_req(OP_RELEASE, 16'hFFFF, 12'hFFF, 6'h3F);  // never-used slot
      add_req(OP_ACQUIRE, 16'h0001, 12'd1, 6'd0);     // reuse of lowest free slot
      add_req(OP_ACQUIRE, 16'h0000, 12'd1, 6'd0);     // same inode, other device
      add_req(OP_ACQUIRE, 16'h0000, 12'd16, 6'd0);    // last inode of a sector
      add_req(OP_ACQUIRE, 16'h0000, 12'd17, 6'd0);    // first inode of the next sector
      add_req(OP_RELEASE, 16'h0000, 12'd0, 6'd1);
      add_req(OP_RELEASE, 16'h0000, 12'd0, 6'd1);
      wait_drain();

      // Zero-sized maps, mixed traffic
      write_reg(CSR_IMAP, '0);
      write_reg(CSR_SMAP, '0);
      queue_mixed(100);
      wait_drain();

      // Largest maps force sector saturation; fill the table under back-pressure
      write_reg(CSR_IMAP, 21'hFF);
      write_reg(CSR_SMAP, 21'h1FFFFF);
      set_idling(82, 9);
      hold_rsp <= 1'b1;
      for (int s = 0; s < SLOTS; s++) begin
         add_req(OP_ACQUIRE, DEV_W'($urandom), 12'(s + 1), SLOT_W'($urandom));
      end
      add_req(OP_ACQUIRE, DEV_W'($urandom), 12'hFFF, SLOT_W'($urandom));   // table full
      add_req(OP_ACQUIRE, DEV_W'($urandom), 12'hFFE, SLOT_W'($urandom));   // table full
      add_req(OP_ACQUIRE, DEV_W'($urandom), 12'd0, SLOT_W'($urandom));     // null, full table
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
      wait_drain();

      // Release every reference in random order, then one release too many
      for (int s = 0; s < SLOTS; s++) begin
         for (int r = 0; r < slot_refs[s]; r++) release_list.push_back(s);
      end
      for (int i = release_list.size() - 1; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = release_list[i];
         release_list[i] = release_list[j];
         release_list[j] = tmp;
      end
      foreach (release_list[i]) begin
         add_req(OP_RELEASE, DEV_W'($urandom), INO_W'($urandom), SLOT_W'(release_list[i]));
      end
      add_req(OP_RELEASE, DEV_W'($urandom), INO_W'($urandom), SLOT_W'($urandom));
      wait_drain();

      // Mid-range maps; drive one key's count into saturation
      write_reg(CSR_IMAP, SECT_W'($urandom_range(1, 255)));
      write_reg(CSR_SMAP, SECT_W'($urandom_range(1, 1048577)));
      sat_dev = DEV_W'($urandom);
      sat_ino = INO_W'($urandom_range(1, 4095));
      for (int i = 0; i < 258; i++) add_req(OP_ACQUIRE, sat_dev, sat_ino, SLOT_W'($urandom));
      for (int i = 0; i < 4; i++) begin
         add_req(OP_RELEASE, DEV_W'($urandom), INO_W'($urandom), 6'd0);
      end
      wait_drain();

      // Back to reset values, no idling on either side
      write_reg(CSR_IMAP, 21'd1);
      write_reg(CSR_SMAP, 21'd1);
      set_idling(0, 0);
      queue_mixed(60);
      wait_drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $display("%0t ns: %0d responses missing, expected status %0d actual none",
                  $time, expected_rsps.size(), expected_rsps[0].status);
         errors++;
      end
      $display("tb: %0d transactions checked: %0d hit/release, %0d load, %0d null, %0d full, %0d bad release",
               rsp_checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4]);
      $display("tb: map settings zero, maximum, mid and reset; input stalled %0d cycles under hold-off",
               input_stalls);
      if (errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
